>>> src/dls_pkg.sv
// shared constants, command codes and control/status types of the dda line stepper
`timescale 1ns / 1ps
`default_nettype none
package dls_pkg;

  localparam int COORD_INT_BITS_DEF  = 12;
  localparam int COORD_FRAC_BITS_DEF = 8;
  localparam int STEP_FRAC_BITS_DEF  = 17;

  localparam int PIX_W   = 13;
  localparam int COLOR_W = 24;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } dls_cmd_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic abs_en;
    logic max_en;
    logic div_init;
    logic div_step;
    logic sign_en;
    logic setup_en;
  } dls_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic mx_zero;
    logic out_stall;
  } dls_stat_t;

endpackage
`default_nettype wire

>>> src/dls_cmd_if.sv
// command channel: load or step commands with line endpoints and colour
`timescale 1ns / 1ps
`default_nettype none
interface dls_cmd_if
  import dls_pkg::*;
#(
  parameter int COORD_W = COORD_INT_BITS_DEF + COORD_FRAC_BITS_DEF + 1
) ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic [COLOR_W-1:0]        line_color;

  modport source (
    output valid, command, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );
  modport sink (
    input  valid, command, start_x, start_y, end_x, end_y, line_color,
    output ready
  );
endinterface
`default_nettype wire

>>> src/dls_pix_if.sv
// pixel channel: one rasterised pixel per item
`timescale 1ns / 1ps
`default_nettype none
interface dls_pix_if
  import dls_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic [COLOR_W-1:0]      pixel_color;
  logic                    last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface
`default_nettype wire

>>> src/dls_ctrl.sv
// controller: line load sequencing, divider iteration count and handshake
`timescale 1ns / 1ps
`default_nettype none
module dls_ctrl
  import dls_pkg::*;
#(
  parameter int STEP_FRAC_BITS = STEP_FRAC_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_command,
  output logic           in_ready,
  input  wire dls_stat_t stat,
  output dls_ctrl_t      ctrl
);

  localparam int QW    = STEP_FRAC_BITS + 2;
  localparam int CNT_W = $clog2(QW);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ABS   = 7'b0000010,
    S_MAX   = 7'b0000100,
    S_INIT  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_SIGN  = 7'b0100000,
    S_SETUP = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_fire;

  assign in_ready = (state_r == S_IDLE) && !stat.out_stall;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    ctrl          = '0;
    ctrl.load     = in_fire && (in_command == CMD_LOAD);
    ctrl.step     = in_fire && (in_command == CMD_STEP);
    ctrl.abs_en   = (state_r == S_ABS);
    ctrl.max_en   = (state_r == S_MAX);
    ctrl.div_init = (state_r == S_INIT);
    ctrl.div_step = (state_r == S_DIV);
    ctrl.sign_en  = (state_r == S_SIGN);
    ctrl.setup_en = (state_r == S_SETUP);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_command == CMD_LOAD)) begin
          state_nxt = S_ABS;
        end
      end
      S_ABS:  state_nxt = S_MAX;
      S_MAX:  state_nxt = S_INIT;
      S_INIT: begin
        // a line shorter than one pixel ends here
        cnt_nxt   = '0;
        state_nxt = stat.mx_zero ? S_IDLE : S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QW - 1)) begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN:  state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/dls_datapath.sv
// datapath: delta/abs/max, two restoring dividers, position accumulators, pixel register
`timescale 1ns / 1ps
`default_nettype none
module dls_datapath
  import dls_pkg::*;
#(
  parameter int COORD_INT_BITS  = COORD_INT_BITS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int STEP_FRAC_BITS  = STEP_FRAC_BITS_DEF,
  parameter int COORD_W         = COORD_INT_BITS + COORD_FRAC_BITS + 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dls_ctrl_t                 ctrl,
  output dls_stat_t                      stat,
  input  wire logic signed [COORD_W-1:0] start_x,
  input  wire logic signed [COORD_W-1:0] start_y,
  input  wire logic signed [COORD_W-1:0] end_x,
  input  wire logic signed [COORD_W-1:0] end_y,
  input  wire logic [COLOR_W-1:0]        line_color,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [PIX_W-1:0]        pixel_x,
  output logic signed [PIX_W-1:0]        pixel_y,
  output logic [COLOR_W-1:0]             pixel_color,
  output logic                           last_pixel
);

  localparam int CF       = COORD_FRAC_BITS;
  localparam int SF       = STEP_FRAC_BITS;
  localparam int MX_W     = COORD_INT_BITS + 1;
  localparam int PL_W     = COORD_INT_BITS + 2;
  localparam int NUM_W    = COORD_W + SF + 1;
  localparam int QW       = SF + 2;
  localparam int STEP_W   = SF + 3;
  localparam int AW       = COORD_INT_BITS + SF + 3;
  localparam int ACC_UP   = (SF >= CF) ? (SF - CF) : 0;
  localparam int ACC_DOWN = (SF >= CF) ? 0 : (CF - SF);
  localparam logic signed [AW-1:0] ONE_ACC = signed'(AW'(1) << SF);
  localparam logic signed [AW-1:0] NEG_ONE = -ONE_ACC;

  logic signed [COORD_W:0]   dx_r, dy_r;
  logic [COORD_W-1:0]        ax_r, ay_r;
  logic                      negx_r, negy_r;
  logic [MX_W-1:0]           mx_r;
  logic [PL_W-1:0]           pl_r;
  logic signed [AW-1:0]      pos_x_r, pos_y_r;
  logic signed [AW-1:0]      tgt_x_r, tgt_y_r;
  // distance to the end point after the next advance
  logic signed [AW-1:0]      ahd_x_r, ahd_y_r;
  logic [NUM_W-1:0]          rem_x_r, rem_y_r, dsh_r;
  logic [QW-1:0]             q_x_r, q_y_r;
  logic signed [STEP_W-1:0]  step_x_r, step_y_r;
  logic [COLOR_W-1:0]        color_r;
  logic                      active_r;
  logic                      out_valid_r;
  logic signed [PIX_W-1:0]   pix_x_r, pix_y_r;
  logic [COLOR_W-1:0]        pix_c_r;
  logic                      last_r;

  logic signed [COORD_W:0]   dx_nxt, dy_nxt;
  logic [COORD_W-1:0]        amax;
  logic                      near_x, near_y, more;
  logic                      ge_x, ge_y;
  logic [PIX_W-1:0]          trunc_x, trunc_y;
  logic                      emit;

  function automatic logic signed [AW-1:0] to_acc(input logic signed [COORD_W-1:0] v);
    logic signed [AW-1:0] e;
    e = AW'(v);
    return (e <<< ACC_UP) >>> ACC_DOWN;
  endfunction

  function automatic logic [PIX_W-1:0] trunc_pix(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] fl;
    logic                 adj;
    fl  = a >>> SF;
    adj = a[AW-1] && (a[SF-1:0] != '0);
    return PIX_W'(fl + AW'(adj));
  endfunction

  assign dx_nxt  = (COORD_W + 1)'(end_x) - (COORD_W + 1)'(start_x);
  assign dy_nxt  = (COORD_W + 1)'(end_y) - (COORD_W + 1)'(start_y);
  assign amax    = (ax_r > ay_r) ? ax_r : ay_r;
  assign ge_x    = (rem_x_r >= dsh_r);
  assign ge_y    = (rem_y_r >= dsh_r);
  assign near_x  = (ahd_x_r > NEG_ONE) && (ahd_x_r < ONE_ACC);
  assign near_y  = (ahd_y_r > NEG_ONE) && (ahd_y_r < ONE_ACC);
  assign more    = (pl_r > PL_W'(1)) && !(near_x && near_y);
  assign trunc_x = trunc_pix(pos_x_r);
  assign trunc_y = trunc_pix(pos_y_r);
  assign emit    = ctrl.step && active_r;

  assign stat.mx_zero   = (mx_r == '0);
  assign stat.out_stall = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      pos_x_r <= to_acc(start_x);
      pos_y_r <= to_acc(start_y);
      tgt_x_r <= to_acc(end_x);
      tgt_y_r <= to_acc(end_y);
      color_r <= line_color;
    end
    if (ctrl.abs_en) begin
      negx_r  <= dx_r[COORD_W];
      negy_r  <= dy_r[COORD_W];
      ax_r    <= COORD_W'(dx_r[COORD_W] ? -dx_r : dx_r);
      ay_r    <= COORD_W'(dy_r[COORD_W] ? -dy_r : dy_r);
      ahd_x_r <= pos_x_r - tgt_x_r;
      ahd_y_r <= pos_y_r - tgt_y_r;
    end
    if (ctrl.max_en) begin
      mx_r <= MX_W'(amax >> CF);
    end
    if (ctrl.div_init) begin
      // numerator carries half the divisor for round to nearest
      rem_x_r <= (NUM_W'(ax_r) << SF) + (NUM_W'(mx_r) << (CF - 1));
      rem_y_r <= (NUM_W'(ay_r) << SF) + (NUM_W'(mx_r) << (CF - 1));
      dsh_r   <= NUM_W'(mx_r) << (CF + QW - 1);
      q_x_r   <= '0;
      q_y_r   <= '0;
      pl_r    <= PL_W'(mx_r) + PL_W'(1);
    end
    if (ctrl.div_step) begin
      rem_x_r <= ge_x ? rem_x_r - dsh_r : rem_x_r;
      rem_y_r <= ge_y ? rem_y_r - dsh_r : rem_y_r;
      q_x_r   <= {q_x_r[QW-2:0], ge_x};
      q_y_r   <= {q_y_r[QW-2:0], ge_y};
      dsh_r   <= dsh_r >> 1;
    end
    if (ctrl.sign_en) begin
      step_x_r <= negx_r ? -STEP_W'(q_x_r) : STEP_W'(q_x_r);
      step_y_r <= negy_r ? -STEP_W'(q_y_r) : STEP_W'(q_y_r);
    end
    if (ctrl.setup_en) begin
      ahd_x_r <= ahd_x_r + AW'(step_x_r);
      ahd_y_r <= ahd_y_r + AW'(step_y_r);
    end
    if (emit) begin
      pos_x_r <= pos_x_r + AW'(step_x_r);
      pos_y_r <= pos_y_r + AW'(step_y_r);
      ahd_x_r <= ahd_x_r + AW'(step_x_r);
      ahd_y_r <= ahd_y_r + AW'(step_y_r);
      pl_r    <= pl_r - PL_W'(1);
      pix_x_r <= signed'(trunc_x);
      pix_y_r <= signed'(trunc_y);
      pix_c_r <= color_r;
      last_r  <= !more;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.load) begin
        active_r <= 1'b0;
      end else if (ctrl.setup_en) begin
        active_r <= 1'b1;
      end else if (emit) begin
        active_r <= more;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign pixel_x     = pix_x_r;
  assign pixel_y     = pix_y_r;
  assign pixel_color = pix_c_r;
  assign last_pixel  = last_r;

endmodule
`default_nettype wire

>>> src/dda_line_stepper_unit.sv
// Fixed-point DDA line stepper. A load item (command 0) takes a line from start to end
// and its colour; each step item (command 1) then returns one pixel, the current position
// truncated toward zero, with last_pixel set on the final one. Steps with no line loaded,
// and loads, return nothing. Step items are taken one per cycle while the pixel register
// is free or being drained. A load keeps the command channel busy through the abs, max,
// divider-init, divide, sign and setup states; the restoring divider forms both axis steps
// at one quotient bit per cycle, and a line shorter than one pixel returns to idle after
// divider-init. A load issued while a line is active replaces it.
`timescale 1ns / 1ps
`default_nettype none
module dda_line_stepper_unit
  import dls_pkg::*;
#(
  parameter int COORD_INT_BITS  = COORD_INT_BITS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int STEP_FRAC_BITS  = STEP_FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  dls_cmd_if.sink  in_ch,
  dls_pix_if.source out_ch
);

  localparam int COORD_W = COORD_INT_BITS + COORD_FRAC_BITS + 1;

  dls_ctrl_t ctrl;
  dls_stat_t stat;

  dls_ctrl #(
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  dls_datapath #(
    .COORD_INT_BITS  (COORD_INT_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .STEP_FRAC_BITS  (STEP_FRAC_BITS),
    .COORD_W         (COORD_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stat        (stat),
    .start_x     (in_ch.start_x),
    .start_y     (in_ch.start_y),
    .end_x       (in_ch.end_x),
    .end_y       (in_ch.end_y),
    .line_color  (in_ch.line_color),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .pixel_x     (out_ch.pixel_x),
    .pixel_y     (out_ch.pixel_y),
    .pixel_color (out_ch.pixel_color),
    .last_pixel  (out_ch.last_pixel)
  );

endmodule
`default_nettype wire

>>> src/dls_checker.sv
// port-level checks of the dda line stepper and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none
module dls_checker
  import dls_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    in_command,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [PIX_W-1:0] out_pixel_x,
  input wire logic signed [PIX_W-1:0] out_pixel_y,
  input wire logic [COLOR_W-1:0]      out_pixel_color,
  input wire logic                    out_last_pixel
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_x) && $stable(out_pixel_y) &&
      $stable(out_pixel_color) && $stable(out_last_pixel))
    else $error("pixel changed while stalled");

  // the divider keeps the command channel busy after a load
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_LOAD) |=> !in_ready)
    else $error("item taken during line setup");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_LOAD) && !out_valid |=> !out_valid)
    else $error("load produced a pixel");

endmodule

bind dda_line_stepper_unit dls_checker u_dls_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_command      (in_ch.command),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_pixel_x     (out_ch.pixel_x),
  .out_pixel_y     (out_ch.pixel_y),
  .out_pixel_color (out_ch.pixel_color),
  .out_last_pixel  (out_ch.last_pixel)
);
`default_nettype wire
